FILE: rtl/pgrf_pkg.sv
// Shared types and constants for the pixel grid rotate and flip block.
package pgrf_pkg;

  localparam int MAX_SIDE  = 32;
  localparam int DEPTH     = MAX_SIDE * MAX_SIDE;
  localparam int IDX_W     = 10;
  localparam int PIX_W     = 24;
  localparam int SIDE_W    = 6;
  localparam int REQ_W     = 3;
  localparam int STS_W     = 2;
  localparam int CFG_IDX_W = 1;
  localparam int PT_W      = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE     = 3'd0,
    REQ_READ      = 3'd1,
    REQ_FILL      = 3'd2,
    REQ_ROT_CW    = 3'd3,
    REQ_ROT_CCW   = 3'd4,
    REQ_MIRROR_LR = 3'd5,
    REQ_MIRROR_TB = 3'd6
  } req_t;

  typedef enum logic [STS_W-1:0] {
    STS_DONE    = 2'd0,
    STS_IGNORED = 2'd1,
    STS_RANGE   = 2'd2
  } sts_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS = 1'b0,
    CFG_COLS = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOOP,
    ST_RD,
    ST_WR,
    ST_RESP,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [IDX_W-1:0] pixel_index;
    logic [PIX_W-1:0] pixel_in;
  } in_req_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic [STS_W-1:0] status;
  } out_res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            accept;
    logic            wr_single;
    logic            rd_single;
    logic            loop_start;
    logic            step_inner;
    logic            step_outer;
    logic            pt_rd;
    logic            pt_wr;
    logic [PT_W-1:0] pt_k;
    logic            out_load;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             idx_ok;
    logic             square;
    logic             outer_end;
    logic             inner_ok;
    logic             out_free;
  } dp_sts_t;

endpackage

FILE: rtl/pgrf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module pgrf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/pgrf_ctrl.sv
// Controller state machine: decodes a request and sequences the grid walks.
module pgrf_ctrl import pgrf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd
);

  state_t          state_r, state_nxt;
  logic [PT_W-1:0] k_r, k_nxt;
  logic            is_rot;
  logic            is_fill;
  logic [PT_W-1:0] k_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

  assign is_rot  = (sts.req == REQ_ROT_CW) || (sts.req == REQ_ROT_CCW);
  assign is_fill = (sts.req == REQ_FILL);
  // A rotation moves four points per step, a mirror swaps two.
  assign k_last  = is_rot ? PT_W'(3) : PT_W'(1);

  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    cmd        = '0;
    cmd.pt_k   = k_r;
    cmd.accept = in_valid && (state_r == ST_IDLE);
    in_stall   = (state_r != ST_IDLE);

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        unique case (sts.req)
          REQ_WRITE: begin
            cmd.wr_single = sts.idx_ok;
            if (sts.out_free) begin
              cmd.out_load = 1'b1;
              state_nxt    = ST_IDLE;
            end else begin
              state_nxt = ST_FIN;
            end
          end
          REQ_READ: begin
            if (sts.idx_ok) begin
              cmd.rd_single = 1'b1;
              state_nxt     = ST_RESP;
            end else if (sts.out_free) begin
              cmd.out_load = 1'b1;
              state_nxt    = ST_IDLE;
            end else begin
              state_nxt = ST_FIN;
            end
          end
          REQ_FILL, REQ_ROT_CW, REQ_ROT_CCW, REQ_MIRROR_LR, REQ_MIRROR_TB: begin
            if (is_rot && !sts.square) begin
              if (sts.out_free) begin
                cmd.out_load = 1'b1;
                state_nxt    = ST_IDLE;
              end else begin
                state_nxt = ST_FIN;
              end
            end else begin
              cmd.loop_start = 1'b1;
              state_nxt      = ST_LOOP;
            end
          end
          default: begin
            if (sts.out_free) begin
              cmd.out_load = 1'b1;
              state_nxt    = ST_IDLE;
            end else begin
              state_nxt = ST_FIN;
            end
          end
        endcase
      end

      ST_LOOP: begin
        priority if (sts.outer_end) begin
          if (sts.out_free) begin
            cmd.out_load = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            state_nxt = ST_FIN;
          end
        end else if (!sts.inner_ok) begin
          cmd.step_outer = 1'b1;
        end else if (is_fill) begin
          cmd.pt_wr      = 1'b1;
          cmd.step_inner = 1'b1;
        end else begin
          state_nxt = ST_RD;
        end
      end

      ST_RD: begin
        cmd.pt_rd = 1'b1;
        if (k_r == k_last) begin
          // Writes start at point one so that every write finds its source
          // already captured; point zero is written last.
          k_nxt     = PT_W'(1);
          state_nxt = ST_WR;
        end else begin
          k_nxt = k_r + PT_W'(1);
        end
      end

      ST_WR: begin
        cmd.pt_wr = 1'b1;
        if (k_r == '0) begin
          cmd.step_inner = 1'b1;
          state_nxt      = ST_LOOP;
        end else if (k_r == k_last) begin
          k_nxt = '0;
        end else begin
          k_nxt = k_r + PT_W'(1);
        end
      end

      ST_RESP, ST_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/pgrf_dp.sv
// Datapath: grid size registers, walk counters, point addressing, pixel store
// and result register.
module pgrf_dp import pgrf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  in_req_t              in_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [SIDE_W-1:0]    cfg_wdata,
  input  logic                 out_stall,
  output logic                 out_valid,
  output out_res_t             out_data,
  input  ctl_cmd_t             cmd,
  output dp_sts_t              sts
);

  localparam int PROD_W = 2 * SIDE_W;

  logic [SIDE_W-1:0] rows_r, cols_r;
  in_req_t           req_r;
  logic [SIDE_W-1:0] o_r, j_r;
  logic [PIX_W-1:0]  h_r [4];
  logic              cap_pend_r;
  logic [PT_W-1:0]   cap_k_r;
  logic              out_valid_r;
  out_res_t          out_data_r;

  logic              is_read, is_write, is_fill, is_lr, is_tb, is_rot, is_ccw;
  logic [PROD_W-1:0] count;
  logic              idx_ok, square;
  logic [SIDE_W-1:0] outer_lim;
  logic              inner_ok;
  logic [SIDE_W:0]   ring_sum;
  logic [SIDE_W-1:0] wm1_o, wm1_j, cm1_j;
  logic [SIDE_W-1:0] pt_row, pt_col;
  logic [PROD_W-1:0] pt_full;
  logic [IDX_W-1:0]  pt_addr;
  logic [PT_W-1:0]   src_k;
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [PIX_W-1:0]  ram_wdata, ram_rdata;
  logic [STS_W-1:0]  res_sts;
  logic [PIX_W-1:0]  res_pix;
  logic              out_free;

  // Out-of-range sizes are clamped when written, so the rest of the logic
  // always sees a side between one and the maximum.
  function automatic logic [SIDE_W-1:0] side_of(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] s;
    if (v == '0) begin
      s = SIDE_W'(1);
    end else if (v > SIDE_W'(MAX_SIDE)) begin
      s = SIDE_W'(MAX_SIDE);
    end else begin
      s = v;
    end
    return s;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= SIDE_W'(8);
      cols_r <= SIDE_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ROWS: rows_r <= side_of(cfg_wdata);
        CFG_COLS: cols_r <= side_of(cfg_wdata);
        default:  rows_r <= rows_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r <= in_data;
    end
  end

  assign is_write = (req_r.req_type == REQ_WRITE);
  assign is_read  = (req_r.req_type == REQ_READ);
  assign is_fill  = (req_r.req_type == REQ_FILL);
  assign is_lr    = (req_r.req_type == REQ_MIRROR_LR);
  assign is_tb    = (req_r.req_type == REQ_MIRROR_TB);
  assign is_ccw   = (req_r.req_type == REQ_ROT_CCW);
  assign is_rot   = (req_r.req_type == REQ_ROT_CW) || is_ccw;

  assign count  = rows_r * cols_r;
  assign idx_ok = {{(PROD_W - IDX_W){1'b0}}, req_r.pixel_index} < count;
  assign square = (rows_r == cols_r);

  // Walk bounds: rows for fill and left-right mirror, columns for top-bottom
  // mirror, rings for rotation.
  always_comb begin
    priority if (is_rot) begin
      outer_lim = rows_r >> 1;
    end else if (is_tb) begin
      outer_lim = cols_r;
    end else begin
      outer_lim = rows_r;
    end
  end

  assign ring_sum = {1'b0, j_r} + {1'b0, o_r} + (SIDE_W + 1)'(1);

  always_comb begin
    priority if (is_rot) begin
      inner_ok = ring_sum < {1'b0, rows_r};
    end else if (is_lr) begin
      inner_ok = j_r < (cols_r >> 1);
    end else if (is_tb) begin
      inner_ok = j_r < (rows_r >> 1);
    end else begin
      inner_ok = j_r < cols_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.loop_start) begin
      o_r <= '0;
      j_r <= '0;
    end else if (cmd.step_outer) begin
      o_r <= o_r + SIDE_W'(1);
      j_r <= is_rot ? (o_r + SIDE_W'(1)) : '0;
    end else if (cmd.step_inner) begin
      j_r <= j_r + SIDE_W'(1);
    end
  end

  assign wm1_o = rows_r - SIDE_W'(1) - o_r;
  assign wm1_j = rows_r - SIDE_W'(1) - j_r;
  assign cm1_j = cols_r - SIDE_W'(1) - j_r;

  // Row and column of the current point. Clockwise visits top, right,
  // bottom, left; counter-clockwise visits top, left, bottom, right.
  always_comb begin
    pt_row = o_r;
    pt_col = j_r;
    priority if (is_lr) begin
      if (cmd.pt_k[0]) begin
        pt_col = cm1_j;
      end
    end else if (is_tb) begin
      pt_row = cmd.pt_k[0] ? wm1_j : j_r;
      pt_col = o_r;
    end else if (is_rot) begin
      unique case (cmd.pt_k)
        2'd0: begin
          pt_row = o_r;
          pt_col = j_r;
        end
        2'd1: begin
          pt_row = is_ccw ? wm1_j : j_r;
          pt_col = is_ccw ? o_r : wm1_o;
        end
        2'd2: begin
          pt_row = wm1_o;
          pt_col = wm1_j;
        end
        default: begin
          pt_row = is_ccw ? j_r : wm1_j;
          pt_col = is_ccw ? wm1_o : o_r;
        end
      endcase
    end else begin
      pt_row = o_r;
      pt_col = j_r;
    end
  end

  assign pt_full = pt_row * cols_r + {{(PROD_W - SIDE_W){1'b0}}, pt_col};
  assign pt_addr = pt_full[IDX_W-1:0];

  // Each point takes the value of the point before it in the cycle.
  assign src_k = is_rot ? (cmd.pt_k - PT_W'(1)) : {1'b0, ~cmd.pt_k[0]};

  // Read data arrives in the cycle after the read is issued.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_pend_r <= 1'b0;
    end else begin
      cap_pend_r <= cmd.pt_rd;
    end
  end

  always_ff @(posedge clk) begin
    cap_k_r <= cmd.pt_k;
    if (cap_pend_r) begin
      h_r[cap_k_r] <= ram_rdata;
    end
  end

  assign ram_we    = cmd.wr_single || cmd.pt_wr;
  assign ram_waddr = cmd.wr_single ? req_r.pixel_index : pt_addr;
  always_comb begin
    priority if (cmd.wr_single || is_fill) begin
      ram_wdata = req_r.pixel_in;
    end else begin
      ram_wdata = h_r[src_k];
    end
  end
  assign ram_re    = cmd.rd_single || cmd.pt_rd;
  assign ram_raddr = cmd.rd_single ? req_r.pixel_index : pt_addr;

  pgrf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    priority if ((is_read || is_write) && !idx_ok) begin
      res_sts = STS_RANGE;
    end else if (is_rot && !square) begin
      res_sts = STS_IGNORED;
    end else begin
      res_sts = STS_DONE;
    end
  end

  assign res_pix = (is_read && idx_ok) ? ram_rdata : '0;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.pixel_out <= res_pix;
      out_data_r.status    <= res_sts;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.req       = req_r.req_type;
  assign sts.idx_ok    = idx_ok;
  assign sts.square    = square;
  assign sts.outer_end = (o_r >= outer_lim);
  assign sts.inner_ok  = inner_ok;
  assign sts.out_free  = out_free;

endmodule

FILE: rtl/pixel_grid_rotate_flip.sv
// Top level of the pixel grid rotate and flip block.
//
// Holds a grid of up to 32 by 32 RGB pixels, row-major, in a single-port-write,
// single-port-read RAM with registered read data, and serves one request at a
// time: the input channel is stalled from the beat after a request is taken
// until its walk is finished and its result is loaded into the output register.
// A finished result waits there without holding up the next request; only a
// later result that finds the register still full waits for it to drain.
// A pixel write, a rejected request or an unused request code is done once
// decoded; a pixel read also passes a response state, since the store's
// registered read port sits in the path. Fill writes one pixel a cycle, with
// an outer step between rows. Mirrors swap pixel pairs by a loop check, two
// reads and two writes (on the one read and one write port), with an outer
// step between rows or columns; rotations move four pixels by a loop check,
// four reads and four writes, with an outer step between rings. The store has
// no reset and needs no clearing pass: a pixel must be written or filled
// before it is read.
module pixel_grid_rotate_flip import pgrf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_req_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_res_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [SIDE_W-1:0]    cfg_wdata
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  pgrf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pgrf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

FILE: rtl/pgrf_checker.sv
// Port-level assertions for the pixel grid rotate and flip block, with bind.
module pgrf_checker import pgrf_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input out_res_t out_data
);

  // A stalled result beat stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Requests are served one at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a request was taken");

  // A new result only ever appears at the end of a request's work.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no request in progress");

  // Rejected or ignored requests carry no pixel.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != STS_DONE) |-> out_data.pixel_out == '0)
    else $error("rejected request returned a nonzero pixel");

endmodule

bind pixel_grid_rotate_flip pgrf_checker u_pgrf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: tb/pixel_grid_rotate_flip_tb.sv
// Self-checking testbench for the pixel grid rotate and flip block.
`timescale 1ns / 100ps

module pixel_grid_rotate_flip_tb;
  import pgrf_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;
  localparam int SETTLE_CYCLES = 16;
  localparam longint LIMIT_CYCLES = 64'd8_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_res_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [SIDE_W-1:0] cfg_wdata = '0;

  // Shadow copy of the grid and its registers.
  logic [SIDE_W-1:0] grid_rows_set = 6'd8;
  logic [SIDE_W-1:0] grid_cols_set = 6'd8;
  logic [PIX_W-1:0] pixels [DEPTH];
  bit pixel_known [DEPTH];
  out_res_t pending_results[$];

  int mismatches = 0;
  longint cycles = 0;
  bit idle_on = 1'b1;

  pixel_grid_rotate_flip u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("pixel_grid_rotate_flip_tb: errors");
      $finish;
    end
  end

  function automatic int side_in_use(logic [SIDE_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_SIDE) return MAX_SIDE;
    return int'(v);
  endfunction

  // Each destination pixel pulls from its source; the known flags travel along.
  function automatic void relocate_pixels(logic [REQ_W-1:0] kind, int rows, int cols);
    logic [PIX_W-1:0] old_pix [DEPTH];
    bit old_known [DEPTH];
    int r, c, src;
    old_pix = pixels;
    old_known = pixel_known;
    for (r = 0; r < rows; r++) begin
      for (c = 0; c < cols; c++) begin
        case (kind)
          REQ_ROT_CW:    src = (rows - 1 - c) * cols + r;
          REQ_ROT_CCW:   src = c * cols + (cols - 1 - r);
          REQ_MIRROR_LR: src = r * cols + (cols - 1 - c);
          default:       src = (rows - 1 - r) * cols + c;
        endcase
        pixels[r * cols + c] = old_pix[src];
        pixel_known[r * cols + c] = old_known[src];
      end
    end
  endfunction

  function automatic out_res_t apply_request(in_req_t rq);
    out_res_t res;
    int rows, cols, cnt, idx, k;
    rows = side_in_use(grid_rows_set);
    cols = side_in_use(grid_cols_set);
    cnt = rows * cols;
    idx = int'(rq.pixel_index);
    res.pixel_out = '0;
    res.status = STS_DONE;
    case (rq.req_type)
      REQ_WRITE: begin
        if (idx < cnt) begin
          pixels[idx] = rq.pixel_in;
          pixel_known[idx] = 1'b1;
        end else begin
          res.status = STS_RANGE;
        end
      end
      REQ_READ: begin
        if (idx < cnt) res.pixel_out = pixels[idx];
        else res.status = STS_RANGE;
      end
      REQ_FILL: begin
        for (k = 0; k < cnt; k++) begin
          pixels[k] = rq.pixel_in;
          pixel_known[k] = 1'b1;
        end
      end
      REQ_ROT_CW, REQ_ROT_CCW: begin
        if (rows != cols) res.status = STS_IGNORED;
        else relocate_pixels(rq.req_type, rows, cols);
      end
      REQ_MIRROR_LR, REQ_MIRROR_TB: begin
        relocate_pixels(rq.req_type, rows, cols);
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Sends one request and records its expected result once the beat is taken.
  task automatic issue(logic [REQ_W-1:0] kind, int idx, logic [PIX_W-1:0] colour);
    in_req_t rq;
    out_res_t expected;
    int gap;
    rq.req_type = kind;
    rq.pixel_index = IDX_W'(idx);
    rq.pixel_in = colour;
    gap = (idle_on && $urandom_range(3) == 0) ? $urandom_range(1, 10) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= rq;
    do @(posedge clk); while (in_stall);
    expected = apply_request(rq);
    pending_results.insert(pending_results.size(), expected);
    // The block stalls its input right after a beat, so valid drops
    // here without losing throughput.
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t which, logic [SIDE_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= which;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (which == CFG_ROWS) grid_rows_set = value;
    else grid_cols_set = value;
  endtask

  // Mostly pixel traffic; in-range reads only land on pixels that hold a known colour.
  task automatic send_random(int xform_pct);
    int cnt, pick, idx, tries;
    bit found;
    logic [REQ_W-1:0] kind;
    cnt = side_in_use(grid_rows_set) * side_in_use(grid_cols_set);
    pick = $urandom_range(99);
    idx = $urandom_range(cnt - 1);
    if (pick < xform_pct) begin
      kind = REQ_W'($urandom_range(REQ_FILL, REQ_MIRROR_TB));
      issue(kind, $urandom_range(1023), PIX_W'($urandom()));
    end else if (pick < xform_pct + 4) begin
      issue(REQ_UNUSED, $urandom_range(1023), PIX_W'($urandom()));
    end else if (pick < xform_pct + 10 && cnt < DEPTH) begin
      kind = $urandom_range(1) ? REQ_READ : REQ_WRITE;
      issue(kind, $urandom_range(DEPTH - 1, cnt), PIX_W'($urandom()));
    end else if (pick < 55) begin
      issue(REQ_WRITE, idx, PIX_W'($urandom()));
    end else begin
      found = pixel_known[idx];
      for (tries = 0; tries < 8 && !found; tries++) begin
        idx = $urandom_range(cnt - 1);
        found = pixel_known[idx];
      end
      issue(found ? REQ_READ : REQ_WRITE, idx, PIX_W'($urandom()));
    end
  endtask

  function automatic logic [SIDE_W-1:0] random_side();
    int pick;
    pick = $urandom_range(99);
    if (pick < 6) return '0;
    if (pick < 10) return SIDE_W'($urandom_range(63, MAX_SIDE + 1));
    if (pick < 14) return SIDE_W'(MAX_SIDE);
    return SIDE_W'($urandom_range(1, 8));
  endfunction

  task automatic test_basic_ops();
    issue(REQ_FILL, 0, 24'hA5A5A5);
    issue(REQ_WRITE, 0, 24'hFFFFFF);
    issue(REQ_WRITE, 63, 24'h000000);
    issue(REQ_WRITE, 1023, 24'hFFFFFF);
    issue(REQ_READ, 0, 24'h000000);
    issue(REQ_READ, 1023, 24'h000000);
    issue(REQ_ROT_CW, 0, 24'h000000);
    issue(REQ_READ, 7, 24'h000000);
    issue(REQ_ROT_CCW, 0, 24'h000000);
    issue(REQ_MIRROR_LR, 0, 24'h000000);
    issue(REQ_MIRROR_TB, 0, 24'h000000);
    issue(REQ_READ, 63, 24'h000000);
    issue(REQ_UNUSED, 1023, 24'hFFFFFF);
  endtask

  task automatic test_odd_shapes();
    // A 4 by 6 grid refuses to rotate but still mirrors.
    wait_idle();
    write_reg(CFG_ROWS, 6'd4);
    write_reg(CFG_COLS, 6'd6);
    issue(REQ_ROT_CW, 0, 24'h000000);
    issue(REQ_MIRROR_TB, 0, 24'h000000);
    issue(REQ_READ, 23, 24'h000000);
    // Zero rows counts as one and 63 columns as the maximum side.
    wait_idle();
    write_reg(CFG_ROWS, 6'd0);
    write_reg(CFG_COLS, 6'd63);
    issue(REQ_WRITE, 31, 24'h00FF00);
    issue(REQ_READ, 32, 24'h000000);
    issue(REQ_ROT_CCW, 0, 24'h000000);
    issue(REQ_READ, 31, 24'h000000);
    wait_idle();
    write_reg(CFG_ROWS, 6'd1);
    write_reg(CFG_COLS, 6'd1);
    issue(REQ_ROT_CW, 0, 24'h000000);
    issue(REQ_READ, 0, 24'h000000);
  endtask

  task automatic test_full_grid();
    int n;
    wait_idle();
    write_reg(CFG_ROWS, 6'd63);
    write_reg(CFG_COLS, SIDE_W'(MAX_SIDE));
    issue(REQ_FILL, 0, PIX_W'($urandom()));
    issue(REQ_WRITE, DEPTH - 1, PIX_W'($urandom()));
    issue(REQ_ROT_CW, 0, 24'h000000);
    issue(REQ_READ, MAX_SIDE - 1, 24'h000000);
    for (n = 0; n < 12; n++) send_random(0);
    issue(REQ_ROT_CCW, 0, 24'h000000);
    issue(REQ_MIRROR_LR, 0, 24'h000000);
    issue(REQ_MIRROR_TB, 0, 24'h000000);
    for (n = 0; n < 16; n++) send_random(0);
  endtask

  task automatic test_random_grids(int phases, int beats_per_phase);
    int p, n, cnt;
    logic [SIDE_W-1:0] rows;
    for (p = 0; p < phases; p++) begin
      wait_idle();
      rows = random_side();
      write_reg(CFG_ROWS, rows);
      write_reg(CFG_COLS, $urandom_range(1) ? rows : random_side());
      cnt = side_in_use(grid_rows_set) * side_in_use(grid_cols_set);
      if ($urandom_range(4) != 0) issue(REQ_FILL, $urandom_range(1023), PIX_W'($urandom()));
      // Whole-grid walks are slow on big grids, so they are kept rare there.
      for (n = 0; n < beats_per_phase; n++) send_random(cnt > 256 ? 2 : 18);
    end
  endtask

  task automatic test_back_to_back();
    int n;
    idle_on = 1'b0;
    wait_idle();
    write_reg(CFG_ROWS, 6'd5);
    write_reg(CFG_COLS, 6'd5);
    issue(REQ_FILL, 0, PIX_W'($urandom()));
    for (n = 0; n < 60; n++) send_random(15);
  endtask

  initial begin : out_stall_gen
    int run;
    forever begin
      run = $urandom_range(1, 20);
      repeat (run) @(negedge clk);
      if (idle_on) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: pixel_out %h status %0d",
               out_data.pixel_out, out_data.status);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.pixel_out !== want.pixel_out) begin
          $error("pixel_out: expected %h, got %h", want.pixel_out, out_data.pixel_out);
          mismatches++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_basic_ops();
    test_odd_shapes();
    test_full_grid();
    test_random_grids(14, 52);
    test_back_to_back();
    wait_idle();
    if (mismatches == 0) $display("pixel_grid_rotate_flip_tb: clean");
    else $display("pixel_grid_rotate_flip_tb: errors");
    $finish;
  end

endmodule

FILE: files.f
rtl/pgrf_pkg.sv
rtl/pgrf_ram.sv
rtl/pgrf_ctrl.sv
rtl/pgrf_dp.sv
rtl/pixel_grid_rotate_flip.sv
rtl/pgrf_checker.sv
tb/pixel_grid_rotate_flip_tb.sv
